// ===== sv/ihc_pkg.sv =====
// ----------------------------------------------------------------------------
// ihc_pkg: shared types and constants of the IPv4 ingress header checker
// Field widths, verdict codes and header length limits.
// ----------------------------------------------------------------------------
package ihc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned VERD_W   = 4;
  localparam int unsigned HLEN_W   = 6;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned DROP_W   = 32;
  localparam int unsigned SUM_W    = 22;
  localparam int unsigned NIBBLE_W = 4;

  localparam logic [LEN_W-1:0]  LEN_MAX       = 16'hFFFF;
  localparam logic [HLEN_W-1:0] IPV4_MIN_HDR  = 6'd20;
  localparam logic [HLEN_W-1:0] TCP_MIN_HDR   = 6'd20;
  localparam logic [HLEN_W-1:0] SMALL_HDR     = 6'd8;
  localparam logic [3:0]        IPV4_VERSION  = 4'd4;

  // Protocol numbers
  localparam logic [BYTE_W-1:0] PROTO_ICMP = 8'd1;
  localparam logic [BYTE_W-1:0] PROTO_TCP  = 8'd6;
  localparam logic [BYTE_W-1:0] PROTO_UDP  = 8'd17;

  // Header byte offsets
  localparam logic [LEN_W-1:0] OFS_TOTLEN_HI = 16'd2;
  localparam logic [LEN_W-1:0] OFS_TOTLEN_LO = 16'd3;
  localparam logic [LEN_W-1:0] OFS_PROTO     = 16'd9;
  localparam logic [LEN_W-1:0] OFS_CHK_HI    = 16'd10;
  localparam logic [LEN_W-1:0] OFS_CHK_LO    = 16'd11;
  localparam logic [6:0]       OFS_TCP_DOFF  = 7'd12;
  localparam logic [6:0]       OFS_UDP_LEN   = 7'd4;

  typedef enum logic [VERD_W-1:0] {
    V_TCP        = 4'd0,
    V_UDP        = 4'd1,
    V_ICMP       = 4'd2,
    V_SHORT      = 4'd3,
    V_VERSION    = 4'd4,
    V_IHL        = 4'd5,
    V_CHECKSUM   = 4'd6,
    V_TOTLEN     = 4'd7,
    V_PROTO      = 4'd8,
    V_TRANS_SHORT = 4'd9,
    V_TRANS_LEN  = 4'd10
  } verdict_t;

endpackage

// ===== sv/ihc_in_if.sv =====
// ----------------------------------------------------------------------------
// ihc_in_if: frame byte channel
// Valid/ready channel carrying one frame byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface ihc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ===== sv/ihc_out_if.sv =====
// ----------------------------------------------------------------------------
// ihc_out_if: verdict channel
// Valid/ready channel carrying one per-frame verdict with header fields.
// ----------------------------------------------------------------------------
interface ihc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [5:0]  header_bytes;
  logic [15:0] datagram_length;
  logic [5:0]  transport_offset_bytes;
  logic [31:0] dropped_total;

  modport source (output valid, output verdict, output header_bytes,
                  output datagram_length, output transport_offset_bytes,
                  output dropped_total, input ready);
  modport sink   (input valid, input verdict, input header_bytes,
                  input datagram_length, input transport_offset_bytes,
                  input dropped_total, output ready);
endinterface

// ===== sv/ipv4_ingress_header_checker_top.sv =====
// ----------------------------------------------------------------------------
// ipv4_ingress_header_checker_top: IPv4 header check with Internet checksum
// Streams a frame byte by byte, captures header fields, accumulates the
// header checksum and gives one verdict request per frame.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                     | when
//  rx      | in  | frame_byte, frame_end                       | one per byte
//  tx      | out | verdict, header_bytes, datagram_length,     | one per frame
//          |     | transport_offset_bytes, dropped_total       |
//
//  One byte per cycle; the verdict is registered in the cycle after the last
//  byte is taken. Field capture, checksum add/fold and the check chain all
//  sit between the frame state registers and the result register.
//  rx is stalled only while a verdict waits in the result register and tx
//  is not ready. Reset (rst, synchronous) clears frame state, drop count
//  and the result valid.
// ----------------------------------------------------------------------------
module ipv4_ingress_header_checker_top (
  input logic      clk,
  input logic      rst,
  ihc_in_if.sink   rx,
  ihc_out_if.source tx
);
  import ihc_pkg::*;

  // Frame state
  logic [LEN_W-1:0]    byte_position;
  logic [NIBBLE_W-1:0] ihl_words;
  logic [NIBBLE_W-1:0] version_seen;
  logic [SUM_W-1:0]    header_sum;
  logic [LEN_W-1:0]    stored_checksum;
  logic [LEN_W-1:0]    total_len_field;
  logic [BYTE_W-1:0]   protocol_field;
  logic [NIBBLE_W-1:0] tcp_offset_words;
  logic [LEN_W-1:0]    udp_len_field;
  logic [DROP_W-1:0]   drop_counter;

  // Next values
  logic [NIBBLE_W-1:0] ihl_words_next;
  logic [NIBBLE_W-1:0] version_seen_next;
  logic [SUM_W-1:0]    header_sum_next;
  logic [LEN_W-1:0]    stored_checksum_next;
  logic [LEN_W-1:0]    total_len_field_next;
  logic [BYTE_W-1:0]   protocol_field_next;
  logic [NIBBLE_W-1:0] tcp_offset_words_next;
  logic [LEN_W-1:0]    udp_len_field_next;
  logic [LEN_W-1:0]    flen;
  logic [HLEN_W-1:0]   hl;
  logic [HLEN_W-1:0]   th;
  logic [SUM_W-1:0]    sum_addend;
  logic [16:0]         fold1;
  logic [16:0]         fold2;
  logic                chk_bad;
  verdict_t            verdict_next;
  logic                accept;
  logic                accept_last;

  assign accept      = rx.valid && rx.ready;
  assign accept_last = accept && rx.frame_end;
  assign rx.ready    = !tx.valid || tx.ready;

  // Field capture for the current byte
  always_comb begin
    version_seen_next     = version_seen;
    ihl_words_next        = ihl_words;
    stored_checksum_next  = stored_checksum;
    total_len_field_next  = total_len_field;
    protocol_field_next   = protocol_field;
    tcp_offset_words_next = tcp_offset_words;
    udp_len_field_next    = udp_len_field;
    if (byte_position == '0) begin
      version_seen_next = rx.frame_byte[7:4];
      ihl_words_next    = rx.frame_byte[3:0];
    end
    hl = {ihl_words_next, 2'b00};
    if (byte_position == OFS_TOTLEN_HI) total_len_field_next[15:8] = rx.frame_byte;
    if (byte_position == OFS_TOTLEN_LO) total_len_field_next[7:0]  = rx.frame_byte;
    if (byte_position == OFS_PROTO)     protocol_field_next        = rx.frame_byte;
    if (byte_position == OFS_CHK_HI)    stored_checksum_next[15:8] = rx.frame_byte;
    if (byte_position == OFS_CHK_LO)    stored_checksum_next[7:0]  = rx.frame_byte;
    if (byte_position == {9'd0, {1'b0, hl} + OFS_TCP_DOFF})
      tcp_offset_words_next = rx.frame_byte[7:4];
    if (byte_position == {9'd0, {1'b0, hl} + OFS_UDP_LEN})
      udp_len_field_next[15:8] = rx.frame_byte;
    if (byte_position == {9'd0, {1'b0, hl} + OFS_UDP_LEN + 7'd1})
      udp_len_field_next[7:0] = rx.frame_byte;

    // Header sum, checksum field excluded
    sum_addend = byte_position[0] ? {14'd0, rx.frame_byte} : {6'd0, rx.frame_byte, 8'd0};
    if (byte_position < {10'd0, hl} && byte_position != OFS_CHK_HI &&
        byte_position != OFS_CHK_LO)
      header_sum_next = header_sum + sum_addend;
    else
      header_sum_next = header_sum;

    flen = (byte_position == LEN_MAX) ? LEN_MAX : byte_position + 16'd1;
  end

  // Check chain, first failure wins
  always_comb begin
    fold1   = {1'b0, header_sum_next[15:0]} + {11'd0, header_sum_next[21:16]};
    fold2   = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
    chk_bad = stored_checksum_next != ~fold2[15:0];
    th      = {tcp_offset_words_next, 2'b00};
    if (flen < {10'd0, IPV4_MIN_HDR}) begin
      verdict_next = V_SHORT;
    end else if (version_seen_next != IPV4_VERSION) begin
      verdict_next = V_VERSION;
    end else if (hl < IPV4_MIN_HDR || {10'd0, hl} > flen) begin
      verdict_next = V_IHL;
    end else if (chk_bad) begin
      verdict_next = V_CHECKSUM;
    end else if (total_len_field_next > flen) begin
      verdict_next = V_TOTLEN;
    end else if (protocol_field_next == PROTO_TCP) begin
      if ({1'b0, total_len_field_next} < {11'd0, hl} + {11'd0, TCP_MIN_HDR})
        verdict_next = V_TRANS_SHORT;
      else if (th < TCP_MIN_HDR ||
               {11'd0, hl} + {11'd0, th} > {1'b0, total_len_field_next})
        verdict_next = V_TRANS_LEN;
      else
        verdict_next = V_TCP;
    end else if (protocol_field_next == PROTO_UDP) begin
      if ({1'b0, total_len_field_next} < {11'd0, hl} + {11'd0, SMALL_HDR})
        verdict_next = V_TRANS_SHORT;
      else if (udp_len_field_next < {10'd0, SMALL_HDR} ||
               {11'd0, hl} + {1'b0, udp_len_field_next} > {1'b0, total_len_field_next})
        verdict_next = V_TRANS_LEN;
      else
        verdict_next = V_UDP;
    end else if (protocol_field_next == PROTO_ICMP) begin
      if ({1'b0, total_len_field_next} < {11'd0, hl} + {11'd0, SMALL_HDR})
        verdict_next = V_TRANS_SHORT;
      else
        verdict_next = V_ICMP;
    end else begin
      verdict_next = V_PROTO;
    end
  end

  // Frame state and drop counter
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      ihl_words        <= '0;
      version_seen     <= '0;
      header_sum       <= '0;
      stored_checksum  <= '0;
      total_len_field  <= '0;
      protocol_field   <= '0;
      tcp_offset_words <= '0;
      udp_len_field    <= '0;
      drop_counter     <= '0;
    end else if (accept) begin
      if (rx.frame_end) begin
        byte_position    <= '0;
        ihl_words        <= '0;
        version_seen     <= '0;
        header_sum       <= '0;
        stored_checksum  <= '0;
        total_len_field  <= '0;
        protocol_field   <= '0;
        tcp_offset_words <= '0;
        udp_len_field    <= '0;
        if (verdict_next >= V_SHORT) drop_counter <= drop_counter + 32'd1;
      end else begin
        byte_position    <= flen;
        ihl_words        <= ihl_words_next;
        version_seen     <= version_seen_next;
        header_sum       <= header_sum_next;
        stored_checksum  <= stored_checksum_next;
        total_len_field  <= total_len_field_next;
        protocol_field   <= protocol_field_next;
        tcp_offset_words <= tcp_offset_words_next;
        udp_len_field    <= udp_len_field_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (accept_last) begin
      tx.valid <= 1'b1;
    end else if (tx.ready) begin
      tx.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_last) begin
      tx.verdict                <= verdict_next;
      tx.header_bytes           <= hl;
      tx.datagram_length        <= total_len_field_next;
      tx.transport_offset_bytes <= (protocol_field_next == PROTO_TCP) ? th : '0;
      tx.dropped_total          <= (verdict_next >= V_SHORT) ? drop_counter + 32'd1
                                                              : drop_counter;
    end
  end

  // Checks
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept_last |=> tx.valid)
    else $error("last byte taken without a verdict");

  a_mid_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !rx.frame_end && !tx.valid) |=> !tx.valid)
    else $error("verdict raised on a non-final byte");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    accept_last |=> (byte_position == '0 && header_sum == '0))
    else $error("frame state not cleared after final byte");

  a_drop_count: assert property (@(posedge clk) disable iff (rst)
    (accept_last && verdict_next >= V_SHORT) |=>
      (drop_counter == $past(drop_counter) + 32'd1))
    else $error("drop count not advanced on a failing frame");

  a_verdict_range: assert property (@(posedge clk) disable iff (rst)
    tx.valid |-> (tx.verdict <= V_TRANS_LEN))
    else $error("verdict code out of range");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the IPv4 ingress header checker
// Streams directed and random IPv4 frames into the byte channel, with random
// idle cycles on both channels and one long verdict back-pressure window.
// A scoreboard predicts each frame's verdict and checks every field of it.
// ----------------------------------------------------------------------------
module tb_top;
  import ihc_pkg::*;

  localparam int unsigned CYCLE_LIMIT       = 1_000_000;
  localparam int unsigned RANDOM_BYTES      = 980;
  localparam int unsigned MIN_RANDOM_FRAMES = 20;
  localparam int unsigned MAX_GAP           = 17;
  localparam int unsigned HOLD_CYCLES       = 1500;
  localparam int unsigned HOLD_AFTER        = 30;
  localparam int unsigned DRAIN_CYCLES      = 8;

  // Ways a random frame gets broken
  typedef enum int {
    BREAK_VERSION, BREAK_IHL, BREAK_SUM, BREAK_TOTLEN, BREAK_PROTO,
    BREAK_DOFF, BREAK_ULEN, BREAK_TRUNC, BREAK_NOISE
  } flaw_t;

  // --------------------------------------------------------------------------
  // Scoreboard: per-frame header tracking and verdict queue
  // --------------------------------------------------------------------------
  class ipv4_verdict_scoreboard;
    typedef struct {
      verdict_t    verdict;
      logic [5:0]  header_bytes;
      logic [15:0] datagram_length;
      logic [5:0]  transport_offset_bytes;
      logic [31:0] dropped_total;
    } verdict_rec_t;

    verdict_rec_t verdicts_due[$];
    int unsigned  errors;
    int unsigned  checked;
    int unsigned  verdict_seen[0:10];

    // frame capture state
    logic [15:0] byte_pos;
    logic [3:0]  ihl_words;
    logic [3:0]  ver;
    logic [21:0] hdr_sum;
    logic [15:0] stored_sum;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [3:0]  tcp_doff;
    logic [15:0] udp_len;
    logic [31:0] drop_count;

    function new();
      drop_count = '0;
      errors     = 0;
      checked    = 0;
      foreach (verdict_seen[i]) verdict_seen[i] = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      byte_pos   = '0;
      ihl_words  = '0;
      ver        = '0;
      hdr_sum    = '0;
      stored_sum = '0;
      total_len  = '0;
      proto      = '0;
      tcp_doff   = '0;
      udp_len    = '0;
    endfunction

    // first failing check, or the accepted protocol class
    function verdict_t classify(int unsigned flen);
      int unsigned hlen;
      int unsigned tlen;
      int unsigned folded;
      hlen   = ihl_words * 4;
      tlen   = tcp_doff * 4;
      folded = hdr_sum;
      folded = (folded & 32'hFFFF) + (folded >> 16);
      folded = (folded & 32'hFFFF) + (folded >> 16);
      if (flen < IPV4_MIN_HDR) return V_SHORT;
      if (ver != IPV4_VERSION) return V_VERSION;
      if (hlen < IPV4_MIN_HDR || hlen > flen) return V_IHL;
      if (stored_sum != 16'(~folded)) return V_CHECKSUM;
      if (total_len > flen) return V_TOTLEN;
      if (proto == PROTO_TCP) begin
        if (total_len < hlen + TCP_MIN_HDR) return V_TRANS_SHORT;
        if (tlen < TCP_MIN_HDR || hlen + tlen > total_len) return V_TRANS_LEN;
        return V_TCP;
      end
      if (proto == PROTO_UDP) begin
        if (total_len < hlen + SMALL_HDR) return V_TRANS_SHORT;
        if (udp_len < SMALL_HDR || hlen + udp_len > total_len) return V_TRANS_LEN;
        return V_UDP;
      end
      if (proto == PROTO_ICMP) begin
        if (total_len < hlen + SMALL_HDR) return V_TRANS_SHORT;
        return V_ICMP;
      end
      return V_PROTO;
    endfunction

    // take one accepted byte request; queue a verdict on the last byte
    function void note_byte(logic [7:0] b, logic last);
      int unsigned  pos;
      int unsigned  hlen;
      int unsigned  flen;
      verdict_rec_t rec;
      pos = byte_pos;
      if (pos == 0) begin
        ver       = b[7:4];
        ihl_words = b[3:0];
      end
      hlen = ihl_words * 4;
      // header words, checksum field counted as zero
      if (pos < hlen && pos != OFS_CHK_HI && pos != OFS_CHK_LO)
        hdr_sum = hdr_sum + (pos[0] ? 22'(b) : 22'({b, 8'h00}));
      if (pos == OFS_TOTLEN_HI) total_len[15:8] = b;
      if (pos == OFS_TOTLEN_LO) total_len[7:0] = b;
      if (pos == OFS_PROTO) proto = b;
      if (pos == OFS_CHK_HI) stored_sum[15:8] = b;
      if (pos == OFS_CHK_LO) stored_sum[7:0] = b;
      if (pos == hlen + OFS_TCP_DOFF) tcp_doff = b[7:4];
      if (pos == hlen + OFS_UDP_LEN) udp_len[15:8] = b;
      if (pos == hlen + OFS_UDP_LEN + 1) udp_len[7:0] = b;
      // byte count sticks at the top
      flen     = (pos >= LEN_MAX) ? LEN_MAX : pos + 1;
      byte_pos = flen;
      if (last) begin
        rec.verdict = classify(flen);
        if (rec.verdict >= V_SHORT) drop_count++;
        rec.header_bytes           = hlen[5:0];
        rec.datagram_length        = total_len;
        rec.transport_offset_bytes = (proto == PROTO_TCP) ? 6'(tcp_doff * 4) : 6'd0;
        rec.dropped_total          = drop_count;
        verdicts_due.push_back(rec);
        restart_frame();
      end
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction

    task report(string what);
      errors++;
      $display("MISMATCH at verdict %0d: %s", checked, what);
    endtask

    task check_verdict(logic [3:0] verdict, logic [5:0] hbytes, logic [15:0] dlen,
                       logic [5:0] tbytes, logic [31:0] drops);
      verdict_rec_t want;
      checked++;
      if (verdicts_due.size() == 0) begin
        report($sformatf("verdict %0d with no frame pending", verdict));
        return;
      end
      want = verdicts_due.pop_front();
      verdict_seen[want.verdict]++;
      if (verdict !== want.verdict)
        report($sformatf("verdict %0d, want %0d (%s)", verdict, want.verdict,
                         want.verdict.name()));
      if (hbytes !== want.header_bytes)
        report($sformatf("header_bytes %0d, want %0d", hbytes, want.header_bytes));
      if (dlen !== want.datagram_length)
        report($sformatf("datagram_length %0d, want %0d", dlen, want.datagram_length));
      if (tbytes !== want.transport_offset_bytes)
        report($sformatf("transport_offset_bytes %0d, want %0d", tbytes,
                         want.transport_offset_bytes));
      if (drops !== want.dropped_total)
        report($sformatf("dropped_total %0d, want %0d", drops, want.dropped_total));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels, block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ihc_in_if  rx_if ();
  ihc_out_if tx_if ();

  ipv4_ingress_header_checker_top u_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .tx  (tx_if)
  );

  ipv4_verdict_scoreboard board = new();

  logic [7:0]  frame_q[$];
  bit          stall_hold = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned verdicts_taken = 0;
  int unsigned cycle_count = 0;
  int unsigned input_stalls = 0;

  function automatic void put_byte(int unsigned idx, logic [7:0] val);
    if (idx < frame_q.size()) frame_q[idx] = val;
  endfunction

  // one byte request; gap idle cycles first, then hold until taken
  task automatic send_byte(logic [7:0] b, logic last, int unsigned gap);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid      <= 1'b1;
    rx_if.frame_byte <= b;
    rx_if.frame_end  <= last;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    board.note_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  // build a frame with the given header fields over random bytes, then send it
  task automatic send_ipv4(logic [3:0] ver, logic [3:0] ihl, logic [15:0] tot,
                           logic [7:0] prot, logic [3:0] doff, logic [15:0] ulen,
                           int unsigned flen, bit good_sum, bit no_gaps);
    int unsigned hlen;
    int unsigned sum;
    int unsigned idx;
    logic [15:0] csum;
    hlen = ihl * 4;
    frame_q.delete();
    for (idx = 0; idx < flen; idx++) frame_q.push_back(8'($urandom_range(0, 255)));
    // transport fields first so that header fields win on overlap
    put_byte(hlen + OFS_UDP_LEN, ulen[15:8]);
    put_byte(hlen + OFS_UDP_LEN + 1, ulen[7:0]);
    put_byte(hlen + OFS_TCP_DOFF, {doff, 4'($urandom_range(0, 15))});
    put_byte(0, {ver, ihl});
    put_byte(OFS_TOTLEN_HI, tot[15:8]);
    put_byte(OFS_TOTLEN_LO, tot[7:0]);
    put_byte(OFS_PROTO, prot);
    // header checksum over the bytes present
    sum = 0;
    for (idx = 0; idx < hlen && idx < flen; idx++)
      if (idx != OFS_CHK_HI && idx != OFS_CHK_LO)
        sum += idx[0] ? {8'h00, frame_q[idx]} : {frame_q[idx], 8'h00};
    sum  = (sum & 32'hFFFF) + (sum >> 16);
    sum  = (sum & 32'hFFFF) + (sum >> 16);
    csum = ~sum[15:0];
    if (!good_sum) csum ^= 16'($urandom_range(1, 65535));
    put_byte(OFS_CHK_HI, csum[15:8]);
    put_byte(OFS_CHK_LO, csum[7:0]);
    for (idx = 0; idx < frame_q.size(); idx++)
      send_byte(frame_q[idx], idx == frame_q.size() - 1,
                no_gaps ? 0 : $urandom_range(0, MAX_GAP));
    frames_sent++;
  endtask

  // mostly well-formed TCP/UDP/ICMP frames, some with one flaw
  task automatic random_frame();
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [7:0]  prot;
    logic [15:0] tot;
    logic [15:0] ulen;
    int unsigned hlen;
    int unsigned flen;
    bit          good;
    flaw_t       flaw;
    ver  = IPV4_VERSION;
    good = 1'b1;
    ihl  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    hlen = ihl * 4;
    doff = 4'($urandom_range(0, 15));
    ulen = 16'($urandom());
    case ($urandom_range(0, 2))
      0: prot = PROTO_TCP;
      1: prot = PROTO_UDP;
      default: prot = PROTO_ICMP;
    endcase
    case (prot)
      PROTO_TCP: begin
        doff = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
        tot  = 16'(hlen + doff * 4 + $urandom_range(0, 16));
      end
      PROTO_UDP: begin
        ulen = 16'(SMALL_HDR + $urandom_range(0, 16));
        tot  = 16'(hlen + ulen + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0));
      end
      default: tot = 16'(hlen + SMALL_HDR + $urandom_range(0, 16));
    endcase
    // link padding after the datagram now and then
    flen = tot + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
    if ($urandom_range(0, 9) < 3) begin
      flaw = flaw_t'($urandom_range(0, BREAK_NOISE));
      case (flaw)
        BREAK_VERSION: ver  = 4'($urandom_range(0, 15));
        BREAK_IHL:     ihl  = 4'($urandom_range(0, 15));
        BREAK_SUM:     good = 1'b0;
        BREAK_TOTLEN:  tot  = $urandom_range(0, 1) ? 16'($urandom())
                                                   : 16'(flen + $urandom_range(1, 20));
        BREAK_PROTO:   prot = 8'($urandom_range(0, 255));
        BREAK_DOFF:    doff = 4'($urandom_range(0, 15));
        BREAK_ULEN:    ulen = 16'($urandom_range(0, 64));
        BREAK_TRUNC:   flen = $urandom_range(1, flen);
        default: begin
          ver  = 4'($urandom_range(0, 15));
          ihl  = 4'($urandom_range(0, 15));
          tot  = 16'($urandom());
          prot = 8'($urandom_range(0, 255));
          flen = $urandom_range(1, 80);
          good = 1'($urandom_range(0, 1));
        end
      endcase
    end
    send_ipv4(ver, ihl, tot, prot, doff, ulen, flen, good, $urandom_range(0, 4) == 0);
  endtask

  // --------------------------------------------------------------------------
  // Verdict side: random ready gaps, plus the long hold window
  // --------------------------------------------------------------------------
  initial begin : verdict_sink
    int unsigned gap;
    tx_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, MAX_GAP);
      if (gap > 0 || stall_hold) begin
        tx_if.ready <= 1'b0;
        while (gap > 0 || stall_hold) begin
          @(negedge clk);
          if (gap > 0) gap--;
        end
      end
      tx_if.ready <= 1'b1;
      @(posedge clk);
      while (!tx_if.valid) @(posedge clk);
      board.check_verdict(tx_if.verdict, tx_if.header_bytes, tx_if.datagram_length,
                          tx_if.transport_offset_bytes, tx_if.dropped_total);
      verdicts_taken++;
      @(negedge clk);
    end
  end

  // hold tx off long enough for the block to fill and stall rx
  initial begin : long_hold
    wait (verdicts_taken >= HOLD_AFTER);
    stall_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    stall_hold = 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
      if (!rst && rx_if.valid && !rx_if.ready) input_stalls++;
    end
    $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
             board.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : frame_source
    int unsigned rand_bytes0;
    int unsigned rand_frames0;
    int unsigned idx;
    verdict_t    vname;
    string       tally;
    rx_if.valid      = 1'b0;
    rx_if.frame_byte = 8'h00;
    rx_if.frame_end  = 1'b0;
    rst              = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // runts
    send_ipv4(IPV4_VERSION, 5, 0, PROTO_TCP, 5, 8, 1, 1, 0);
    send_ipv4(IPV4_VERSION, 5, 19, PROTO_TCP, 5, 8, 19, 1, 0);
    // version and IHL
    send_ipv4(4'd6, 5, 40, PROTO_TCP, 5, 8, 40, 1, 0);
    send_ipv4(IPV4_VERSION, 4, 40, PROTO_TCP, 5, 8, 40, 1, 0);
    send_ipv4(IPV4_VERSION, 0, 40, PROTO_TCP, 5, 8, 40, 1, 0);
    send_ipv4(IPV4_VERSION, 15, 50, PROTO_TCP, 5, 8, 50, 1, 0);
    // checksum and total length
    send_ipv4(IPV4_VERSION, 5, 40, PROTO_TCP, 5, 8, 40, 0, 0);
    send_ipv4(IPV4_VERSION, 5, 41, PROTO_TCP, 5, 8, 40, 1, 0);
    send_ipv4(IPV4_VERSION, 5, 16'hFFFF, PROTO_UDP, 5, 8, 100, 1, 0);
    // unknown protocols
    send_ipv4(IPV4_VERSION, 5, 40, 8'h00, 5, 8, 40, 1, 0);
    send_ipv4(IPV4_VERSION, 5, 40, 8'hFF, 5, 8, 40, 1, 0);
    // TCP: short, bad data offsets, accepted at min and max header sizes
    send_ipv4(IPV4_VERSION, 5, 39, PROTO_TCP, 5, 8, 39, 1, 0);
    send_ipv4(IPV4_VERSION, 5, 40, PROTO_TCP, 4, 8, 40, 1, 0);
    send_ipv4(IPV4_VERSION, 5, 40, PROTO_TCP, 0, 8, 40, 1, 0);
    send_ipv4(IPV4_VERSION, 5, 40, PROTO_TCP, 6, 8, 40, 1, 0);
    send_ipv4(IPV4_VERSION, 5, 40, PROTO_TCP, 5, 8, 40, 1, 0);
    send_ipv4(IPV4_VERSION, 15, 120, PROTO_TCP, 15, 8, 120, 1, 0);
    // UDP: short, length below header, past datagram, accepted with trailer
    send_ipv4(IPV4_VERSION, 5, 27, PROTO_UDP, 5, 8, 27, 1, 0);
    send_ipv4(IPV4_VERSION, 5, 28, PROTO_UDP, 5, 7, 28, 1, 0);
    send_ipv4(IPV4_VERSION, 5, 28, PROTO_UDP, 5, 16'hFFFF, 28, 1, 0);
    send_ipv4(IPV4_VERSION, 5, 28, PROTO_UDP, 5, 9, 28, 1, 0);
    send_ipv4(IPV4_VERSION, 5, 28, PROTO_UDP, 5, 8, 31, 1, 0);
    // ICMP: short, accepted with options
    send_ipv4(IPV4_VERSION, 5, 27, PROTO_ICMP, 5, 8, 27, 1, 0);
    send_ipv4(IPV4_VERSION, 6, 32, PROTO_ICMP, 5, 8, 32, 1, 0);

    // random traffic
    rand_bytes0  = bytes_sent;
    rand_frames0 = frames_sent;
    while (bytes_sent - rand_bytes0 < RANDOM_BYTES ||
           frames_sent - rand_frames0 < MIN_RANDOM_FRAMES)
      random_frame();

    rx_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    tally = "";
    for (idx = 0; idx <= V_TRANS_LEN; idx++) begin
      vname = verdict_t'(idx);
      tally = {tally, $sformatf(" %s=%0d", vname.name(), board.verdict_seen[idx])};
    end
    $display("%0d frames, %0d bytes in %0d cycles; rx stalled %0d cycles under tx hold",
             frames_sent, bytes_sent, cycle_count, input_stalls);
    $display("verdicts checked:%s", tally);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== ipv4_ingress_header_checker_top.f =====
sv/ihc_pkg.sv
sv/ihc_in_if.sv
sv/ihc_out_if.sv
sv/ipv4_ingress_header_checker_top.sv
test/tb_top.sv
